// ===== design/crs_pkg.sv =====
// Shared constants and types for the Catmull-Rom spline evaluator.
// Used by the point store, the axis pipeline and the top level; no dependencies.
`default_nettype none

package crs_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int COORD_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 5;
  localparam int POS_W    = FRAC_BITS + 1;
  localparam int IDX_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int AXIS_LAT = 7;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] i0;
    logic [IDX_W-1:0] i1;
    logic [IDX_W-1:0] i2;
    logic [IDX_W-1:0] i3;
  } crs_idx_t;

  typedef logic [3:0][COORD_W-1:0] coord_quad_t;

endpackage

`default_nettype wire

// ===== design/catmull_rom_spline_eval.sv =====
// Top level of the uniform Catmull-Rom spline evaluator.
// Depends on crs_pkg, crs_point_store and crs_axis_pipe.
`default_nettype none

// The block takes one transaction per clock cycle and never raises busy; cfg_ready
// is always high. A load transaction writes one control point and gives no result.
// An evaluate transaction gives exactly one result: out_valid is high for one cycle.
// The depth is set by the position register, the segment lookup with the point
// store read, the coefficient register, the three dependent multiply and add steps of
// the Horner evaluation with a register after each multiply and after the first two
// adds, and the saturation register, which also takes the last add. The receiver
// cannot stall the block, so results leave in the order the evaluations arrived.
// A point must be loaded before an evaluation reads it.

module catmull_rom_spline_eval
  import crs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_mode,
  input  wire logic [SLOT_W-1:0]         in_point_index,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  input  wire logic signed [COORD_W-1:0] in_coord_z,
  input  wire logic [POS_W-1:0]          in_position,
  output logic                           out_valid,
  output logic signed [COORD_W-1:0]      out_x,
  output logic signed [COORD_W-1:0]      out_y,
  output logic signed [COORD_W-1:0]      out_z,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  localparam int VLD_LEN = AXIS_LAT + 2;
  localparam int SCL_W   = POS_W + IDX_W;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;

  logic                   accept;
  logic                   eval_acc;
  logic                   load_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [POS_W-1:0]       pos_sat;
  logic [IDX_W-1:0]       last_nxt;
  logic [SCL_W-1:0]       scaled;
  logic [IDX_W:0]         seg;
  logic [IDX_W-1:0]       s;
  crs_idx_t               idx;
  coord_quad_t            px_q, py_q, pz_q;
  logic [VLD_LEN-1:0]     vld_nxt;

  logic [IDX_W-1:0]       last_r;
  logic [VLD_LEN-1:0]     vld_r;
  logic [POS_W-1:0]       pos1_r;
  logic [FRAC_BITS-1:0]   f2_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign eval_acc  = accept && (in_mode == MODE_EVAL);
  assign load_en   = accept && (in_mode == MODE_LOAD) && (int'(in_point_index) < MAX_POINTS);
  assign wr_addr   = IDX_W'(in_point_index);
  assign pos_sat   = (in_position > POS_ONE) ? POS_ONE : in_position;
  assign vld_nxt   = {vld_r[VLD_LEN-2:0], eval_acc};

  always_comb begin
    if (cfg_data == '0) begin
      last_nxt = '0;
    end else if (int'(cfg_data) > MAX_POINTS) begin
      last_nxt = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_nxt = IDX_W'(cfg_data - CFG_W'(1));
    end
  end

  always_comb begin
    scaled = SCL_W'(pos1_r) * SCL_W'(last_r);
    seg    = scaled[SCL_W-1:FRAC_BITS];
    s      = (seg > {1'b0, last_r}) ? last_r : seg[IDX_W-1:0];
    idx.i1 = s;
    idx.i0 = (s != '0) ? s - IDX_W'(1) : '0;
    idx.i2 = (s < last_r) ? s + IDX_W'(1) : last_r;
    idx.i3 = (({1'b0, s} + (IDX_W+1)'(2)) <= {1'b0, last_r}) ? s + IDX_W'(2) : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= IDX_W'(MAX_POINTS - 1);
      vld_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        last_r <= last_nxt;
      end
      vld_r <= vld_nxt;
    end
    pos1_r <= pos_sat;
    f2_r   <= scaled[FRAC_BITS-1:0];
  end

  crs_point_store u_store_x (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (wr_addr),
    .wr_data (in_coord_x),
    .rd_idx  (idx),
    .rd_data (px_q)
  );

  crs_point_store u_store_y (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (wr_addr),
    .wr_data (in_coord_y),
    .rd_idx  (idx),
    .rd_data (py_q)
  );

  crs_point_store u_store_z (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (wr_addr),
    .wr_data (in_coord_z),
    .rd_idx  (idx),
    .rd_data (pz_q)
  );

  crs_axis_pipe u_axis_x (
    .clk (clk),
    .p   (px_q),
    .f   (f2_r),
    .res (out_x)
  );

  crs_axis_pipe u_axis_y (
    .clk (clk),
    .p   (py_q),
    .f   (f2_r),
    .res (out_y)
  );

  crs_axis_pipe u_axis_z (
    .clk (clk),
    .p   (pz_q),
    .f   (f2_r),
    .res (out_z)
  );

  assign out_valid = vld_r[VLD_LEN-1];

`ifndef SYNTHESIS
  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(eval_acc, VLD_LEN))
    else $error("result without an evaluate transaction");

  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && eval_acc) |-> ##VLD_LEN out_valid)
    else $error("evaluate transaction lost");

  a_neighbors_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (idx.i0 <= idx.i1 && idx.i1 <= idx.i2 && idx.i2 <= idx.i3
                  && idx.i3 <= last_r))
    else $error("neighbor indices out of order");

  a_zero_fraction: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(f2_r == '0, AXIS_LAT)) |-> (out_x == $past(px_q[1], AXIS_LAT)))
    else $error("zero fraction does not give the segment start point");
`endif

endmodule

`default_nettype wire

// ===== design/crs_point_store.sv =====
// Control point storage for one axis: two copies, each with two read ports.
// Depends on crs_pkg for the index struct and widths.
`default_nettype none

module crs_point_store
  import crs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [COORD_W-1:0] wr_data,
  input  wire crs_idx_t           rd_idx,
  output coord_quad_t             rd_data
);

  logic [COORD_W-1:0] mem_lo_r [MAX_POINTS];
  logic [COORD_W-1:0] mem_hi_r [MAX_POINTS];
  coord_quad_t        rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo_r[wr_addr] <= wr_data;
      mem_hi_r[wr_addr] <= wr_data;
    end
    rd_q_r[0] <= mem_lo_r[rd_idx.i0];
    rd_q_r[1] <= mem_lo_r[rd_idx.i1];
    rd_q_r[2] <= mem_hi_r[rd_idx.i2];
    rd_q_r[3] <= mem_hi_r[rd_idx.i3];
  end

  assign rd_data = rd_q_r;

endmodule

`default_nettype wire

// ===== design/crs_axis_pipe.sv =====
// Pipelined Horner evaluation of the Catmull-Rom cubic for one axis.
// Depends on crs_pkg for widths; seven register stages from inputs to result.
`default_nettype none

module crs_axis_pipe
  import crs_pkg::*;
(
  input  wire logic                      clk,
  input  wire coord_quad_t               p,
  input  wire logic [FRAC_BITS-1:0]      f,
  output logic signed [COORD_W-1:0]      res
);

  localparam int A_W   = COORD_W + 1;
  localparam int C_W   = COORD_W + 4;
  localparam int D_W   = COORD_W + 3;
  localparam int ACC_W = COORD_W + 5;
  localparam int M1_W  = D_W + FRAC_BITS + 1;
  localparam int MA_W  = ACC_W + FRAC_BITS + 1;

  logic signed [C_W-1:0]   e0, e1, e2, e3;
  logic signed [A_W-1:0]   a_nxt, b_nxt;
  logic signed [C_W-1:0]   c_nxt;
  logic signed [D_W-1:0]   d_nxt;
  logic signed [M1_W-1:0]  m1_nxt;
  logic signed [ACC_W-1:0] acc1_nxt, acc2_nxt, acc3;
  logic signed [MA_W-1:0]  m2_nxt, m3_nxt;
  logic signed [ACC_W-2:0] half;
  logic signed [COORD_W-1:0] res_nxt;

  logic signed [A_W-1:0]   a_c_r, a_m1_r, a_a1_r, a_m2_r, a_a2_r, a_m3_r;
  logic signed [A_W-1:0]   b_c_r, b_m1_r, b_a1_r, b_m2_r;
  logic signed [C_W-1:0]   c_c_r, c_m1_r;
  logic signed [D_W-1:0]   d_c_r;
  logic [FRAC_BITS-1:0]    f_c_r, f_m1_r, f_a1_r, f_m2_r, f_a2_r;
  logic signed [M1_W-1:0]  m1_r;
  logic signed [ACC_W-1:0] acc1_r, acc2_r;
  logic signed [MA_W-1:0]  m2_r, m3_r;
  logic signed [COORD_W-1:0] res_r;

  assign e0 = C_W'($signed(p[0]));
  assign e1 = C_W'($signed(p[1]));
  assign e2 = C_W'($signed(p[2]));
  assign e3 = C_W'($signed(p[3]));

  assign a_nxt = A_W'(e1 <<< 1);
  assign b_nxt = A_W'(e2 - e0);
  assign c_nxt = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign d_nxt = D_W'((e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0);

  assign m1_nxt   = d_c_r * $signed({1'b0, f_c_r});
  assign acc1_nxt = ACC_W'($signed(m1_r[M1_W-1:FRAC_BITS])) + ACC_W'(c_m1_r);
  assign m2_nxt   = acc1_r * $signed({1'b0, f_a1_r});
  assign acc2_nxt = ACC_W'($signed(m2_r[MA_W-1:FRAC_BITS])) + ACC_W'(b_m2_r);
  assign m3_nxt   = acc2_r * $signed({1'b0, f_a2_r});
  assign acc3     = ACC_W'($signed(m3_r[MA_W-1:FRAC_BITS])) + ACC_W'(a_m3_r);
  assign half     = acc3[ACC_W-1:1];

  always_comb begin
    if ((&half[ACC_W-2:COORD_W-1]) || !(|half[ACC_W-2:COORD_W-1])) begin
      res_nxt = half[COORD_W-1:0];
    end else if (half[ACC_W-2]) begin
      res_nxt = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    a_c_r  <= a_nxt;
    b_c_r  <= b_nxt;
    c_c_r  <= c_nxt;
    d_c_r  <= d_nxt;
    f_c_r  <= f;

    m1_r   <= m1_nxt;
    a_m1_r <= a_c_r;
    b_m1_r <= b_c_r;
    c_m1_r <= c_c_r;
    f_m1_r <= f_c_r;

    acc1_r <= acc1_nxt;
    a_a1_r <= a_m1_r;
    b_a1_r <= b_m1_r;
    f_a1_r <= f_m1_r;

    m2_r   <= m2_nxt;
    a_m2_r <= a_a1_r;
    b_m2_r <= b_a1_r;
    f_m2_r <= f_a1_r;

    acc2_r <= acc2_nxt;
    a_a2_r <= a_m2_r;
    f_a2_r <= f_m2_r;

    m3_r   <= m3_nxt;
    a_m3_r <= a_a2_r;

    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== verif/catmull_rom_spline_eval_checker.sv =====
// Checker for the Catmull-Rom spline evaluator: mirrors the control point store and the
// point count register, predicts every evaluated point and compares the results.
// Depends on crs_pkg; instantiated beside the block by catmull_rom_spline_eval_tb.
`timescale 1ns / 100ps

module catmull_rom_spline_eval_checker
  import crs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic                      in_mode,
  input  wire logic [SLOT_W-1:0]         in_point_index,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  input  wire logic signed [COORD_W-1:0] in_coord_z,
  input  wire logic [POS_W-1:0]          in_position,
  input  wire logic                      out_valid,
  input  wire logic signed [COORD_W-1:0] out_x,
  input  wire logic signed [COORD_W-1:0] out_y,
  input  wire logic signed [COORD_W-1:0] out_z,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [CFG_W-1:0]          cfg_data,
  output int                             fail_count,
  output int                             points_in_flight
);

  localparam logic [CFG_W-1:0] COUNT_AT_RESET = 5'd16;
  localparam longint SAT_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (COORD_W - 1));

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } spline_point_t;

  logic signed [COORD_W-1:0] ctrl_x [MAX_POINTS];
  logic signed [COORD_W-1:0] ctrl_y [MAX_POINTS];
  logic signed [COORD_W-1:0] ctrl_z [MAX_POINTS];
  logic [CFG_W-1:0]          count_reg = COUNT_AT_RESET;
  spline_point_t             expected_points [$];
  int                        errors = 0;

  // Horner evaluation of the cubic; every arithmetic shift rounds toward minus infinity.
  function automatic logic signed [COORD_W-1:0] catmull_rom_axis(
    longint p0, longint p1, longint p2, longint p3, longint f);
    longint a, b, c, d, acc;
    a = 2 * p1;
    b = p2 - p0;
    c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    d = -p0 + 3 * p1 - 3 * p2 + p3;
    acc = ((d * f) >>> FRAC_BITS) + c;
    acc = ((acc * f) >>> FRAC_BITS) + b;
    acc = ((acc * f) >>> FRAC_BITS) + a;
    acc = acc >>> 1;
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    return acc[COORD_W-1:0];
  endfunction

  function automatic spline_point_t predict_point(logic [POS_W-1:0] pos_in);
    int unsigned   pos, n, scaled, seg, last, i0, i1, i2, i3;
    longint        f;
    spline_point_t r;
    pos = pos_in;
    if (pos > (1 << FRAC_BITS)) pos = 1 << FRAC_BITS;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    scaled = pos * (n - 1);
    seg    = scaled >> FRAC_BITS;
    f      = scaled & ((1 << FRAC_BITS) - 1);
    last   = n - 1;
    if (seg > last) seg = last;
    i0 = (seg > 0) ? seg - 1 : 0;
    i1 = seg;
    i2 = (seg < last) ? seg + 1 : last;
    i3 = (seg + 2 <= last) ? seg + 2 : last;
    r.x = catmull_rom_axis(ctrl_x[i0], ctrl_x[i1], ctrl_x[i2], ctrl_x[i3], f);
    r.y = catmull_rom_axis(ctrl_y[i0], ctrl_y[i1], ctrl_y[i2], ctrl_y[i3], f);
    r.z = catmull_rom_axis(ctrl_z[i0], ctrl_z[i1], ctrl_z[i2], ctrl_z[i3], f);
    return r;
  endfunction

  task automatic check_axis(string axis, logic signed [COORD_W-1:0] want,
                            logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: out_%s mismatch, expected %0d actual %0d", $time, axis, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    spline_point_t want;
    if (!rst_n) begin
      count_reg = COUNT_AT_RESET;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (out_valid) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result, expected none actual x=%0d y=%0d z=%0d",
                   $time, out_x, out_y, out_z);
          errors++;
        end else begin
          want = expected_points.pop_front();
          check_axis("x", want.x, out_x);
          check_axis("y", want.y, out_y);
          check_axis("z", want.z, out_z);
        end
      end
      if (start && !busy) begin
        if (in_mode == MODE_LOAD) begin
          ctrl_x[in_point_index] = in_coord_x;
          ctrl_y[in_point_index] = in_coord_y;
          ctrl_z[in_point_index] = in_coord_z;
        end else begin
          expected_points.push_back(predict_point(in_position));
        end
      end
    end
    fail_count       <= errors;
    points_in_flight <= expected_points.size();
  end

endmodule

// ===== verif/catmull_rom_spline_eval_tb.sv =====
// Testbench top for catmull_rom_spline_eval: drives load and evaluate transactions and
// point count writes, and gives the verdict from the failure count of the checker.
// Depends on crs_pkg, catmull_rom_spline_eval and catmull_rom_spline_eval_checker.
`timescale 1ns / 100ps

module catmull_rom_spline_eval_tb;
  import crs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 60;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      start          = 1'b0;
  logic                      in_mode        = MODE_LOAD;
  logic [SLOT_W-1:0]         in_point_index = '0;
  logic signed [COORD_W-1:0] in_coord_x     = '0;
  logic signed [COORD_W-1:0] in_coord_y     = '0;
  logic signed [COORD_W-1:0] in_coord_z     = '0;
  logic [POS_W-1:0]          in_position    = '0;
  logic                      cfg_valid      = 1'b0;
  logic [CFG_W-1:0]          cfg_data       = '0;
  logic                      busy;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      cfg_ready;
  int                        fail_count;
  int                        points_in_flight;
  int                        cycle_count    = 0;
  bit                        idling         = 1'b0;

  always #5 clk = ~clk;

  catmull_rom_spline_eval DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_point_index (in_point_index),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  catmull_rom_spline_eval_checker spline_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_point_index   (in_point_index),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .points_in_flight (points_in_flight)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL catmull_rom_spline_eval");
      $finish;
    end
  end

  // Coordinates within +/-16.0 so the cubic stays in range, or extremes or random words.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -1;
      4, 5:    return $urandom;
      default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return POS_W'(1 << FRAC_BITS);
      2:       return POS_W'($urandom_range((1 << FRAC_BITS) + 1, (1 << POS_W) - 1));
      3:       return POS_W'((1 << FRAC_BITS) - 1);
      default: return POS_W'($urandom_range(0, 1 << FRAC_BITS));
    endcase
  endfunction

  task automatic send_item(logic mode, logic [SLOT_W-1:0] slot,
                           logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                           logic signed [COORD_W-1:0] z, logic [POS_W-1:0] pos);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_point_index <= slot;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    in_position    <= pos;
    do @(posedge clk); while (busy);
  endtask

  // Register writes happen only with the pipeline drained.
  task automatic set_point_count(logic [CFG_W-1:0] value);
    start <= 1'b0;
    do @(posedge clk); while (points_in_flight != 0);
    repeat (DRAIN_CYCLES + $urandom_range(0, 8)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [POS_W-1:0] corner_pos [5];
    logic [CFG_W-1:0] phase_count [PHASES];
    corner_pos  = '{POS_W'(0), POS_W'(1 << (FRAC_BITS - 1)), POS_W'((1 << FRAC_BITS) - 1),
                    POS_W'(1 << FRAC_BITS), POS_W'((1 << POS_W) - 1)};
    phase_count = '{5'd16, 5'd31, 5'd2, 5'd0, 5'd17, 5'd3, 5'd1,
                    5'($urandom_range(0, 31)), 5'd16};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every slot first so that no evaluation ever reads an unwritten point.
    for (int s = 0; s < MAX_POINTS; s++) begin
      send_item(MODE_LOAD, s[SLOT_W-1:0], s[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF,
                (s * 3 - 20) * (1 << FRAC_BITS), pick_coord(), POS_W'($urandom));
    end
    foreach (corner_pos[k]) begin
      send_item(MODE_EVAL, SLOT_W'($urandom), $urandom, $urandom, $urandom, corner_pos[k]);
    end
    set_point_count(5'd1);
    send_item(MODE_EVAL, SLOT_W'($urandom), $urandom, $urandom, $urandom, POS_W'(40000));
    set_point_count(5'd0);
    send_item(MODE_EVAL, SLOT_W'($urandom), $urandom, $urandom, $urandom,
              POS_W'((1 << POS_W) - 1));
    set_point_count(5'd2);
    send_item(MODE_EVAL, SLOT_W'($urandom), $urandom, $urandom, $urandom,
              POS_W'(1 << (FRAC_BITS - 1)));

    for (int ph = 0; ph < PHASES; ph++) begin
      set_point_count(phase_count[ph]);
      idling = (ph < PHASES - 1);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 4) begin
          send_item(MODE_LOAD, SLOT_W'($urandom), pick_coord(), pick_coord(), pick_coord(),
                    POS_W'($urandom));
        end else begin
          send_item(MODE_EVAL, SLOT_W'($urandom), $urandom, $urandom, $urandom,
                    pick_position());
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (points_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS catmull_rom_spline_eval");
    end else begin
      $display("FAIL catmull_rom_spline_eval");
    end
    $finish;
  end

endmodule
